### design/stlk_pkg.sv
// shared types and field constants for the sorted table lookup block
package stlk_pkg;

    // fixed field widths of the stream payload
    localparam int CMD_W     = 2;
    localparam int KEY_F_W   = 32;
    localparam int VALUE_W   = 32;
    localparam int ENTRIES_W = 9;
    localparam int S_TDATA_W = 64;
    localparam int M_TDATA_W = 48;

    // request kinds carried in s_tuser, code 3 is unused
    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 2'd0,
        CMD_LOOKUP = 2'd1,
        CMD_CLEAR  = 2'd2
    } cmd_t;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_SHIFT,
        ST_PLACE,
        ST_RESP
    } state_t;

endpackage

### design/stlk_store.sv
// key/value pair store: one write port, one read port with registered read data
module stlk_store
    import stlk_pkg::*;
#(
    parameter int DEPTH = 256,
    parameter int KEY_W = 32,
    localparam int AW   = $clog2(DEPTH)
)
(
    input  logic               clk,
    input  logic               wr_en,
    input  logic [AW-1:0]      wr_addr,
    input  logic [KEY_W-1:0]   wr_key,
    input  logic [VALUE_W-1:0] wr_value,
    input  logic [AW-1:0]      rd_addr,
    output logic [KEY_W-1:0]   rd_key,
    output logic [VALUE_W-1:0] rd_value
);

    logic [KEY_W+VALUE_W-1:0] mem [DEPTH];
    logic [KEY_W+VALUE_W-1:0] rd_word_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= {wr_key, wr_value};
        end
    end

    // read port, read data registered
    always_ff @(posedge clk)
    begin
        rd_word_reg <= mem[rd_addr];
    end

    assign rd_key   = rd_word_reg[KEY_W+VALUE_W-1:VALUE_W];
    assign rd_value = rd_word_reg[VALUE_W-1:0];

endmodule

### design/sorted_table_binary_lookup.sv
// Sorted key/value table with binary search lookup. Pairs live in one
// DEPTH-entry memory in ascending key order; an insert goes after all
// entries with an equal or lower key, a lookup returns the value of the
// first binary-search probe that matches, clear empties the table. Each
// request gives exactly one result. The memory has one read port with
// registered read data, so each search probe reads one entry; a hit ends
// a lookup early, an insert moves every entry above the insertion point
// up by one before placing the new pair, and clear, a refused insert and
// an unused command go straight to the result. A new request is taken
// while the previous result still waits in the output register.
module sorted_table_binary_lookup
    import stlk_pkg::*;
#(
    parameter int DEPTH     = 256,
    parameter int KEY_WIDTH = 32
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,  // key[31:0], value[63:32]
    input  logic [CMD_W-1:0]     s_tuser,  // cmd[1:0]
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata   // found[0], fixup[32:1], status[33],
                                           // entries[42:34], zero[47:43]
);

    localparam int KW = (KEY_WIDTH < KEY_F_W) ? KEY_WIDTH : KEY_F_W;
    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    state_t               state_reg, state_next;
    cmd_t                 cmd_reg, cmd_next;
    logic [KW-1:0]        key_reg, key_next;
    logic [VALUE_W-1:0]   value_reg, value_next;
    logic [CW-1:0]        count_reg, count_next;
    logic [CW-1:0]        lo_reg, lo_next;
    logic [CW-1:0]        end_reg, end_next;
    logic [AW-1:0]        mid_reg, mid_next;
    logic [AW-1:0]        src_reg, src_next;
    logic                 found_reg, found_next;
    logic [VALUE_W-1:0]   fixup_reg, fixup_next;
    logic                 status_reg, status_next;
    logic                 m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    cmd_t                 in_cmd;
    logic [KW-1:0]        in_key;
    logic                 wr_en;
    logic [AW-1:0]        wr_addr;
    logic [KW-1:0]        wr_key;
    logic [VALUE_W-1:0]   wr_value;
    logic [AW-1:0]        rd_addr;
    logic [KW-1:0]        rd_key;
    logic [VALUE_W-1:0]   rd_value;

    logic                 probe_eq;
    logic                 probe_lt;
    logic                 probe_le;
    logic [CW-1:0]        lo_step, end_step;
    logic [CW-1:0]        lo_src, end_src;
    logic [CW:0]          mid_sum;
    logic [AW-1:0]        pos;

    stlk_store #(
        .DEPTH (DEPTH),
        .KEY_W (KW)
    ) u_store (
        .clk      (clk),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_key   (wr_key),
        .wr_value (wr_value),
        .rd_addr  (rd_addr),
        .rd_key   (rd_key),
        .rd_value (rd_value)
    );

    assign in_cmd   = cmd_t'(s_tuser);
    assign in_key   = s_tdata[KW-1:0];
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign pos      = lo_reg[AW-1:0];

    // probe compare and next search window
    assign probe_eq = (rd_key == key_reg);
    assign probe_lt = (rd_key < key_reg);
    assign probe_le = probe_lt || probe_eq;

    always_comb
    begin
        lo_step  = lo_reg;
        end_step = end_reg;
        if ((cmd_reg == CMD_LOOKUP) ? probe_lt : probe_le)
        begin
            lo_step = CW'(mid_reg) + CW'(1);
        end
        else
        begin
            end_step = CW'(mid_reg);
        end
    end

    // probe address: midpoint of the window, fresh window on a new request
    assign lo_src  = (state_reg == ST_SEARCH) ? lo_step : '0;
    assign end_src = (state_reg == ST_SEARCH) ? end_step : count_reg;
    assign mid_sum = {1'b0, lo_src} + {1'b0, end_src} - (CW+1)'(1);

    // sequencer next state and memory control
    always_comb
    begin
        state_next    = state_reg;
        cmd_next      = cmd_reg;
        key_next      = key_reg;
        value_next    = value_reg;
        count_next    = count_reg;
        lo_next       = lo_reg;
        end_next      = end_reg;
        mid_next      = mid_reg;
        src_next      = src_reg;
        found_next    = found_reg;
        fixup_next    = fixup_reg;
        status_next   = status_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        rd_addr       = mid_sum[AW:1];
        wr_en         = 1'b0;
        wr_addr       = src_reg + AW'(1);
        wr_key        = rd_key;
        wr_value      = rd_value;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd_next    = in_cmd;
                    key_next    = in_key;
                    value_next  = s_tdata[KEY_F_W +: VALUE_W];
                    found_next  = 1'b0;
                    fixup_next  = '0;
                    status_next = 1'b0;
                    lo_next     = '0;
                    end_next    = count_reg;
                    mid_next    = mid_sum[AW:1];
                    unique case (in_cmd)
                        CMD_INSERT:
                        begin
                            if (count_reg == CW'(DEPTH))
                            begin
                                status_next = 1'b1;
                                state_next  = ST_RESP;
                            end
                            else if (count_reg == '0)
                            begin
                                state_next = ST_PLACE;
                            end
                            else
                            begin
                                state_next = ST_SEARCH;
                            end
                        end
                        CMD_LOOKUP:
                        begin
                            state_next = (count_reg == '0) ? ST_RESP : ST_SEARCH;
                        end
                        CMD_CLEAR:
                        begin
                            count_next = '0;
                            state_next = ST_RESP;
                        end
                        default:
                        begin
                            state_next = ST_RESP;
                        end
                    endcase
                end
            end

            ST_SEARCH:
            begin
                if ((cmd_reg == CMD_LOOKUP) && probe_eq)
                begin
                    found_next = 1'b1;
                    fixup_next = rd_value;
                    state_next = ST_RESP;
                end
                else
                begin
                    lo_next  = lo_step;
                    end_next = end_step;
                    mid_next = mid_sum[AW:1];
                    if (lo_step < end_step)
                    begin
                        state_next = ST_SEARCH;
                    end
                    else if (cmd_reg == CMD_LOOKUP)
                    begin
                        state_next = ST_RESP;
                    end
                    else if (lo_step == count_reg)
                    begin
                        state_next = ST_PLACE;
                    end
                    else
                    begin
                        // move the upper part of the table up by one, top entry first
                        src_next   = AW'(count_reg - CW'(1));
                        rd_addr    = AW'(count_reg - CW'(1));
                        state_next = ST_SHIFT;
                    end
                end
            end

            ST_SHIFT:
            begin
                wr_en = 1'b1;
                if (src_reg == pos)
                begin
                    state_next = ST_PLACE;
                end
                else
                begin
                    src_next = src_reg - AW'(1);
                    rd_addr  = src_reg - AW'(1);
                end
            end

            ST_PLACE:
            begin
                wr_en      = 1'b1;
                wr_addr    = pos;
                wr_key     = key_reg;
                wr_value   = value_reg;
                count_next = count_reg + CW'(1);
                state_next = ST_RESP;
            end

            ST_RESP:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = M_TDATA_W'({ENTRIES_W'(count_reg), status_reg,
                                                fixup_reg, found_reg});
                    state_next    = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // request payload, search window and result registers
    always_ff @(posedge clk)
    begin
        cmd_reg     <= cmd_next;
        key_reg     <= key_next;
        value_reg   <= value_next;
        lo_reg      <= lo_next;
        end_reg     <= end_next;
        mid_reg     <= mid_next;
        src_reg     <= src_next;
        found_reg   <= found_next;
        fixup_reg   <= fixup_next;
        status_reg  <= status_next;
        m_tdata_reg <= m_tdata_next;
    end

`ifndef ASSERT_OFF
    // the table never holds more than its depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("entry count above table depth");

    // a search cycle always has a non-empty window
    a_window: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SEARCH) |-> (lo_reg < end_reg))
        else $error("search running on an empty window");

    // shifting never moves entries below the insertion point
    a_shift_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SHIFT) |-> (src_reg >= pos && CW'(src_reg) < count_reg))
        else $error("shift outside the moved range");

    // a clear request empties the table in the next cycle
    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tuser == CMD_CLEAR) |=> (count_reg == '0))
        else $error("clear did not empty the table");

    // a refused insert only happens on a full table
    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RESP && status_reg) |-> (count_reg == CW'(DEPTH)))
        else $error("insert refused on a table that is not full");
`endif

endmodule

### dv/tb_sorted_table_binary_lookup.sv
// testbench for the sorted table binary lookup block: directed rows, then random episodes
`timescale 1ns / 100ps

module tb_sorted_table_binary_lookup;

    import stlk_pkg::*;

    localparam int TABLE_DEPTH   = 256;
    localparam int TOTAL_ITEMS   = 1650;
    localparam int MAX_REPORTS   = 10;
    localparam int HOLD_CYCLES   = 300;
    localparam int DRAIN_CYCLES  = 600;
    localparam int TIMEOUT_NS    = 10_000_000;
    localparam int DIRECTED_ROWS = 18;

    // code 3 has no member in the package enum
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    // one result, packed in m_tdata order from bit 0 up
    typedef struct packed {
        logic [ENTRIES_W-1:0] entries;
        logic                 status;
        logic [VALUE_W-1:0]   fixup;
        logic                 found;
    } table_result_t;

    localparam int RESULT_W = $bits(table_result_t);

    // directed request with an optional hand-written result
    typedef struct packed {
        logic [CMD_W-1:0]     cmd;
        logic [KEY_F_W-1:0]   key;
        logic [VALUE_W-1:0]   value;
        logic                 typed;
        logic                 exp_found;
        logic [VALUE_W-1:0]   exp_fixup;
        logic                 exp_status;
        logic [ENTRIES_W-1:0] exp_entries;
    } directed_row_t;

    localparam directed_row_t DIRECTED_TABLE [DIRECTED_ROWS] = '{
        // lookup on an empty table
        '{CMD_LOOKUP, 32'h0000_0000, 32'h0000_0000, 1'b1, 1'b0, 32'h0, 1'b0, 9'd0},
        // unused command changes nothing
        '{CMD_UNUSED, 32'hDEAD_BEEF, 32'h1234_5678, 1'b1, 1'b0, 32'h0, 1'b0, 9'd0},
        '{CMD_CLEAR,  32'h0000_0000, 32'h0000_0000, 1'b1, 1'b0, 32'h0, 1'b0, 9'd0},
        '{CMD_INSERT, 32'h0000_0000, 32'h0000_0000, 1'b1, 1'b0, 32'h0, 1'b0, 9'd1},
        // match whose fixup is zero
        '{CMD_LOOKUP, 32'h0000_0000, 32'h0000_0000, 1'b1, 1'b1, 32'h0, 1'b0, 9'd1},
        '{CMD_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b0, 32'h0, 1'b0, 9'd2},
        '{CMD_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 1'b1, 32'hFFFF_FFFF, 1'b0, 9'd2},
        // equal keys keep arrival order
        '{CMD_INSERT, 32'h8000_0000, 32'h5555_5555, 1'b0, 1'b0, 32'h0, 1'b0, 9'd0},
        '{CMD_INSERT, 32'h8000_0000, 32'hAAAA_AAAA, 1'b0, 1'b0, 32'h0, 1'b0, 9'd0},
        '{CMD_LOOKUP, 32'h8000_0000, 32'hFFFF_FFFF, 1'b0, 1'b0, 32'h0, 1'b0, 9'd0},
        '{CMD_LOOKUP, 32'h7FFF_FFFF, 32'h0000_0000, 1'b0, 1'b0, 32'h0, 1'b0, 9'd0},
        '{CMD_INSERT, 32'h1234_5678, 32'hA5A5_A5A5, 1'b0, 1'b0, 32'h0, 1'b0, 9'd0},
        '{CMD_INSERT, 32'h0000_0001, 32'h0000_0001, 1'b0, 1'b0, 32'h0, 1'b0, 9'd0},
        '{CMD_LOOKUP, 32'h0000_0001, 32'h0000_0000, 1'b0, 1'b0, 32'h0, 1'b0, 9'd0},
        '{CMD_LOOKUP, 32'hFFFF_FFFE, 32'h0000_0000, 1'b0, 1'b0, 32'h0, 1'b0, 9'd0},
        '{CMD_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b0, 32'h0, 1'b0, 9'd0},
        '{CMD_CLEAR,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b0, 32'h0, 1'b0, 9'd0},
        '{CMD_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 1'b0, 32'h0, 1'b0, 9'd0}
    };

    logic                 clk      = 1'b0;
    logic                 rst_n    = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic [CMD_W-1:0]     s_tuser  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    // shadow copy of the sorted table
    logic [KEY_F_W-1:0] held_keys   [TABLE_DEPTH];
    logic [VALUE_W-1:0] held_values [TABLE_DEPTH];
    int                 held_count = 0;

    table_result_t expected_results [$];
    int unsigned   mismatch_count  = 0;
    int unsigned   results_seen    = 0;
    int unsigned   requests_sent   = 0;
    int unsigned   send_burst_left = 0;
    table_result_t observed;
    table_result_t wanted;

    sorted_table_binary_lookup #(
        .DEPTH     (TABLE_DEPTH),
        .KEY_WIDTH (KEY_F_W)
    ) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #2 clk = ~clk;

    // apply one request to the shadow table and return its result
    function automatic table_result_t predict_request(input logic [CMD_W-1:0] cmd,
                                                      input logic [KEY_F_W-1:0] key,
                                                      input logic [VALUE_W-1:0] value);
        int            pos;
        int            idx;
        int            lo;
        int            hi;
        int            mid;
        table_result_t res;
        res = '0;
        unique case (cmd)
            CMD_INSERT:
            begin
                if (held_count >= TABLE_DEPTH)
                begin
                    res.status = 1'b1;
                end
                else
                begin
                    // stable placement after all keys less or equal
                    pos = 0;
                    while (pos < held_count && held_keys[pos] <= key)
                        pos++;
                    for (idx = held_count; idx > pos; idx--)
                    begin
                        held_keys[idx]   = held_keys[idx-1];
                        held_values[idx] = held_values[idx-1];
                    end
                    held_keys[pos]   = key;
                    held_values[pos] = value;
                    held_count++;
                end
            end
            CMD_LOOKUP:
            begin
                // first probe that matches wins
                lo = 0;
                hi = held_count - 1;
                while (lo <= hi && !res.found)
                begin
                    mid = lo + (hi - lo) / 2;
                    if (held_keys[mid] == key)
                    begin
                        res.found = 1'b1;
                        res.fixup = held_values[mid];
                    end
                    else if (held_keys[mid] < key)
                        lo = mid + 1;
                    else
                        hi = mid - 1;
                end
            end
            CMD_CLEAR:
                held_count = 0;
            default:
                ;
        endcase
        res.entries = held_count[ENTRIES_W-1:0];
        return res;
    endfunction

    // narrow keys bunch up to give duplicates and hits
    function automatic logic [KEY_F_W-1:0] pick_key(input bit narrow,
                                                    input logic [KEY_F_W-1:0] base);
        return narrow ? base + $urandom_range(0, 15) : $urandom;
    endfunction

    // offer one request, wait for acceptance, queue its expected result
    task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [KEY_F_W-1:0] key,
                                input logic [VALUE_W-1:0] value, input bit typed,
                                input table_result_t typed_res);
        int unsigned   gap;
        table_result_t predicted;
        if (send_burst_left > 0)
        begin
            gap = 0;
            send_burst_left--;
        end
        else
        begin
            gap = $urandom_range(0, 12);
            if ($urandom_range(0, 50) == 0)
                send_burst_left = $urandom_range(16, 64);
        end
        if (gap > 0)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= {value, key};
        s_tuser  <= cmd;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predicted = predict_request(cmd, key, value);
        expected_results.push_back(typed ? typed_res : predicted);
        requests_sent++;
    endtask

    // result sink with random stalls and two long hold-offs
    initial
    begin : result_sink
        int unsigned gap;
        int unsigned burst_left;
        int unsigned hold_stage;
        burst_left = 0;
        hold_stage = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (hold_stage < 2 && results_seen >= (hold_stage == 0 ? 120 : 1000))
            begin
                hold_stage++;
                @(negedge clk);
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            if (burst_left > 0)
            begin
                gap = 0;
                burst_left--;
            end
            else
            begin
                gap = $urandom_range(0, 12);
                if ($urandom_range(0, 50) == 0)
                    burst_left = $urandom_range(16, 64);
            end
            if (gap > 0)
            begin
                @(negedge clk);
                m_tready <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
            @(negedge clk);
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid)
                @(posedge clk);
        end
    end

    // compare each accepted result with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            results_seen <= results_seen + 1;
            observed = m_tdata[RESULT_W-1:0];
            if (expected_results.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("unexpected result: found=%0b fixup=%h status=%0b entries=%0d",
                             observed.found, observed.fixup, observed.status,
                             observed.entries);
            end
            else
            begin
                wanted = expected_results.pop_front();
                if (observed.found !== wanted.found || observed.fixup !== wanted.fixup ||
                    observed.status !== wanted.status || observed.entries !== wanted.entries)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("result %0d: expected found=%0b fixup=%h status=%0b %s%0d%s",
                                 results_seen, wanted.found, wanted.fixup, wanted.status,
                                 "entries=", wanted.entries, ",");
                    if (mismatch_count <= MAX_REPORTS)
                        $display("    got found=%0b fixup=%h status=%0b entries=%0d",
                                 observed.found, observed.fixup, observed.status,
                                 observed.entries);
                end
            end
        end
    end

    // run limit
    initial
    begin
        #(TIMEOUT_NS);
        $display("sorted_table_binary_lookup: mismatch");
        $finish;
    end

    // reset, directed rows, random episodes, drain
    initial
    begin
        int unsigned        row;
        int unsigned        step;
        int unsigned        fill_count;
        int unsigned        probe_count;
        int unsigned        roll;
        bit                 narrow;
        bit                 first_fill;
        logic [KEY_F_W-1:0] key_base;
        logic [KEY_F_W-1:0] key;
        logic [CMD_W-1:0]   cmd;
        directed_row_t      cur;

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed rows
        for (row = 0; row < DIRECTED_ROWS; row++)
        begin
            cur = DIRECTED_TABLE[row];
            send_request(cur.cmd, cur.key, cur.value, cur.typed,
                         {cur.exp_entries, cur.exp_status, cur.exp_fixup, cur.exp_found});
        end

        // random episodes: optional clear, a run of mostly inserts, then mostly lookups
        first_fill = 1'b1;
        while (requests_sent < TOTAL_ITEMS)
        begin
            narrow   = ($urandom_range(0, 2) == 0);
            key_base = $urandom;
            if (first_fill)
                fill_count = TABLE_DEPTH + 4;
            else if ($urandom_range(0, 7) == 0)
                fill_count = $urandom_range(40, 120);
            else
                fill_count = $urandom_range(1, 24);

            if (first_fill || $urandom_range(0, 3) != 0)
                send_request(CMD_CLEAR, $urandom, $urandom, 1'b0, '0);

            // fill phase, the first one is all inserts and runs into the full table
            for (step = 0; step < fill_count && requests_sent < TOTAL_ITEMS; step++)
            begin
                roll = first_fill ? 15 : $urandom_range(0, 15);
                if (roll == 0)
                    cmd = CMD_UNUSED;
                else if (roll == 1)
                    cmd = CMD_LOOKUP;
                else
                    cmd = CMD_INSERT;
                send_request(cmd, pick_key(narrow, key_base), $urandom, 1'b0, '0);
            end

            // lookup phase, mostly stored keys and their neighbors
            probe_count = $urandom_range(fill_count / 2 + 1, fill_count + 8);
            for (step = 0; step < probe_count && requests_sent < TOTAL_ITEMS; step++)
            begin
                roll = $urandom_range(0, 39);
                cmd  = CMD_LOOKUP;
                if (roll == 0)
                    cmd = CMD_CLEAR;
                else if (roll <= 2)
                    cmd = CMD_UNUSED;
                if (roll <= 26 && held_count > 0)
                    key = held_keys[$urandom_range(0, held_count - 1)];
                else if (roll <= 32 && held_count > 0)
                    key = held_keys[$urandom_range(0, held_count - 1)] +
                          ((roll & 1) ? 32'd1 : 32'hFFFF_FFFF);
                else
                    key = pick_key(narrow, key_base);
                send_request(cmd, key, $urandom, 1'b0, '0);
            end
            first_fill = 1'b0;
        end

        @(negedge clk);
        s_tvalid <= 1'b0;

        // wait out the last results, then watch for strays
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("sorted_table_binary_lookup: match");
        else
            $display("sorted_table_binary_lookup: mismatch");
        $finish;
    end

endmodule
